// ===== rtl/arpc_pkg.sv =====
package arpc_pkg;

  localparam int TableDepthDef = 16;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;

  localparam logic [CfgAddrW-1:0] ADDR_HOST_IP  = 4'h0;
  localparam logic [CfgAddrW-1:0] ADDR_HOST_MAC = 4'h8;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_ip;
    logic [47:0] req_mac;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] result_mac;
  } rsp_t;

  // table write commands from the engine, at most one set per cycle
  typedef struct packed {
    logic add;
    logic set_mac;
    logic clr;
    logic set_local;
  } tbl_op_t;

  // CAM search summary for the item in the input register
  typedef struct packed {
    logic        ip_any;
    logic        del_any;
    logic        free_any;
    logic [47:0] hit_mac;
  } cam_look_t;

endpackage

// ===== rtl/arpc_cam.sv =====
module arpc_cam
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] req_ip,
  input  logic [47:0] req_mac,
  input  tbl_op_t     op,
  output cam_look_t   look
);

  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0]            ent_ip  [TABLE_DEPTH];
  logic [47:0]            ent_mac [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] ip_vec, del_vec, free_vec;
  logic [TABLE_DEPTH-1:0] ip_oh, del_oh, free_oh;
  logic [TABLE_DEPTH-1:0] one;
  logic [47:0]            hit_mac;

  assign one = {{(TABLE_DEPTH-1){1'b0}}, 1'b1};

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ip_vec[i]  = valid[i] && (ent_ip[i] == req_ip);
      del_vec[i] = ip_vec[i] && (ent_mac[i] == req_mac);
    end
  end

  assign free_vec = ~valid;

  // lowest set bit
  assign ip_oh   = ip_vec & (~ip_vec + one);
  assign del_oh  = del_vec & (~del_vec + one);
  assign free_oh = free_vec & (~free_vec + one);

  always_comb begin
    hit_mac = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_mac = hit_mac | (ip_oh[i] ? ent_mac[i] : 48'd0);
    end
  end

  assign look.ip_any   = |ip_vec;
  assign look.del_any  = |del_vec;
  assign look.free_any = |free_vec;
  assign look.hit_mac  = hit_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (op.add && free_oh[i]) begin
          valid[i] <= 1'b1;
        end else if (op.clr && del_oh[i]) begin
          valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (op.add && free_oh[i]) begin
        ent_ip[i]  <= req_ip;
        ent_mac[i] <= req_mac;
      end else if (op.set_mac && ip_oh[i]) begin
        ent_mac[i] <= req_mac;
      end
    end
  end

`ifndef ASSERT_OFF
  a_ip_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(ip_vec))
    else $error("arpc_cam: one IP held by several valid entries");
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    op.add |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("arpc_cam: insert did not fill exactly one slot");
  a_clr_shrinks: assert property (@(posedge clk) disable iff (rst)
    op.clr |=> $countones(valid) + 1 == $past($countones(valid)))
    else $error("arpc_cam: delete did not free exactly one slot");
  a_add_has_room: assert property (@(posedge clk) disable iff (rst)
    op.add |-> look.free_any && !look.ip_any)
    else $error("arpc_cam: insert issued without a free slot or on a duplicate");
`endif

endmodule

// ===== rtl/arpc_engine.sv =====
module arpc_engine
  import arpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_vld,
  input  req_t        req_q,
  input  logic [31:0] host_ip,
  input  logic [47:0] host_mac_cur,
  input  cam_look_t   look,
  output tbl_op_t     op,
  output logic        rsp_vld,
  output rsp_t        rsp_q
);

  logic    local_hit;
  status_t status_next;
  logic [47:0] mac_next;
  tbl_op_t op_raw;

  assign local_hit = (req_q.req_ip == host_ip);

  always_comb begin
    status_next = ST_NOT_FOUND;
    mac_next    = '0;
    op_raw      = '0;
    case (req_kind_t'(req_q.req_type))
      REQ_LOOKUP: begin
        if (local_hit) begin
          status_next = ST_DONE;
          mac_next    = host_mac_cur;
        end else if (look.ip_any) begin
          status_next = ST_DONE;
          mac_next    = look.hit_mac;
        end
      end
      REQ_INSERT: begin
        if (local_hit || look.ip_any) begin
          status_next = ST_PRESENT;
        end else if (look.free_any) begin
          status_next = ST_DONE;
          op_raw.add  = 1'b1;
        end else begin
          status_next = ST_FULL;
        end
      end
      REQ_UPDATE: begin
        if (local_hit) begin
          status_next      = ST_DONE;
          op_raw.set_local = 1'b1;
        end else if (look.ip_any) begin
          status_next    = ST_DONE;
          op_raw.set_mac = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (look.del_any) begin
          status_next = ST_DONE;
          op_raw.clr  = 1'b1;
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  assign op = req_vld ? op_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else begin
      rsp_vld <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      rsp_q.status     <= status_next;
      rsp_q.result_mac <= mac_next;
    end
  end

`ifndef ASSERT_OFF
  a_op_single: assert property (@(posedge clk) disable iff (rst) $onehot0(op))
    else $error("arpc_engine: more than one table write in a cycle");
  a_op_needs_item: assert property (@(posedge clk) disable iff (rst)
    (op != '0) |-> req_vld)
    else $error("arpc_engine: table write without an item");
  a_mac_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && (rsp_q.status != ST_DONE) |-> rsp_q.result_mac == 48'd0)
    else $error("arpc_engine: MAC returned on a failed request");
`endif

endmodule

// ===== rtl/arp_cache_table.sv =====
// An item taken on start is registered in req_q; the engine then registers its result into rsp with done.
// Throughput: one item per cycle; busy stays low, the CAM searches all entries at once.
// Each result is on rsp for exactly one cycle; the receiver cannot stall.
// Reset (rst, synchronous): all entries invalid, both host address registers and
// the local entry's MAC cleared; no clearing pass, ready on the cycle after reset.
module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  output logic                done,
  output rsp_t                rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic        req_vld;
  req_t        req_q;
  logic [31:0] host_ip;
  logic [47:0] host_mac;
  logic [47:0] host_mac_cur, host_mac_cur_next;
  logic        cfg_wr;
  tbl_op_t     op;
  cam_look_t   look;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  always_comb begin
    host_mac_cur_next = host_mac_cur;
    if (cfg_wr && paddr == ADDR_HOST_MAC) begin
      host_mac_cur_next = pwdata[47:0];
    end else if (op.set_local) begin
      host_mac_cur_next = req_q.req_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_ip      <= '0;
      host_mac     <= '0;
      host_mac_cur <= '0;
    end else begin
      if (cfg_wr && paddr == ADDR_HOST_IP) begin
        host_ip <= pwdata[31:0];
      end
      if (cfg_wr && paddr == ADDR_HOST_MAC) begin
        host_mac <= pwdata[47:0];
      end
      host_mac_cur <= host_mac_cur_next;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_HOST_IP:  prdata = {32'd0, host_ip};
      ADDR_HOST_MAC: prdata = {16'd0, host_mac};
      default:       prdata = '0;
    endcase
  end

  arpc_cam #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_cam (
    .clk     (clk),
    .rst     (rst),
    .req_ip  (req_q.req_ip),
    .req_mac (req_q.req_mac),
    .op      (op),
    .look    (look)
  );

  arpc_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .req_vld      (req_vld),
    .req_q        (req_q),
    .host_ip      (host_ip),
    .host_mac_cur (host_mac_cur),
    .look         (look),
    .op           (op),
    .rsp_vld      (done),
    .rsp_q        (rsp)
  );

`ifndef ASSERT_OFF
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("arpc top: item produced no result");
  a_local_upd: assert property (@(posedge clk) disable iff (rst)
    op.set_local && !cfg_wr |=> host_mac_cur == $past(req_q.req_mac))
    else $error("arpc top: local MAC update lost");
  a_cfg_mac: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && paddr == ADDR_HOST_MAC |=> host_mac_cur == host_mac)
    else $error("arpc top: local MAC write not mirrored");
`endif

endmodule

// ===== test/arp_cache_table_tb.sv =====
module arp_cache_table_tb;
  import arpc_pkg::*;

  localparam int Depth = TableDepthDef;
  localparam int PoolSize = 24;
  localparam int CycleLimit = 60000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    req_kind_t   kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        typed;
    status_t     st;
    logic [47:0] rmac;
  } vec_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  req_t                req;
  logic                done;
  rsp_t                rsp;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // predictor copy of the table
  logic        slot_valid [Depth];
  logic [31:0] slot_ip [Depth];
  logic [47:0] slot_mac [Depth];
  logic [31:0] own_ip;
  logic [47:0] own_mac;

  logic [31:0] ip_pool [PoolSize];
  rsp_t        answer_q [$];
  vec_t        dir_tab [$];
  int          mismatches;
  int          cycles;
  int          seen [4];

  arp_cache_table uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles, answer_q.size());
      $display("arp_cache_table regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected answer status %0d mac %h", $time, rsp.status,
                 rsp.result_mac);
      end else begin
        want = answer_q.pop_front();
        seen[want.status]++;
        if (rsp.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
        end
        if (rsp.result_mac !== want.result_mac) begin
          mismatches++;
          $display("%0t: mac expected %h got %h", $time, want.result_mac,
                   rsp.result_mac);
        end
      end
    end
  end

  function automatic int find_slot(logic [31:0] ip);
    int idx;
    idx = -1;
    for (int i = 0; i < Depth; i++)
      if (idx < 0 && slot_valid[i] && slot_ip[i] == ip) idx = i;
    return idx;
  endfunction

  function automatic rsp_t arp_resolve(req_t r);
    rsp_t o;
    int   k;
    logic hit;
    o.status = ST_NOT_FOUND;
    o.result_mac = '0;
    k = find_slot(r.req_ip);
    hit = 1'b0;
    case (req_kind_t'(r.req_type))
      REQ_LOOKUP: begin
        if (r.req_ip == own_ip) begin
          o.status = ST_DONE;
          o.result_mac = own_mac;
        end else if (k >= 0) begin
          o.status = ST_DONE;
          o.result_mac = slot_mac[k];
        end
      end
      REQ_INSERT: begin
        if (r.req_ip == own_ip || k >= 0) begin
          o.status = ST_PRESENT;
        end else begin
          o.status = ST_FULL;
          for (int i = 0; i < Depth; i++) begin
            if (!hit && !slot_valid[i]) begin
              hit = 1'b1;
              slot_valid[i] = 1'b1;
              slot_ip[i] = r.req_ip;
              slot_mac[i] = r.req_mac;
              o.status = ST_DONE;
            end
          end
        end
      end
      REQ_UPDATE: begin
        if (r.req_ip == own_ip) begin
          own_mac = r.req_mac;
          o.status = ST_DONE;
        end else if (k >= 0) begin
          slot_mac[k] = r.req_mac;
          o.status = ST_DONE;
        end
      end
      REQ_DELETE: begin
        // local entry is never removed
        for (int i = 0; i < Depth; i++) begin
          if (!hit && slot_valid[i] && slot_ip[i] == r.req_ip && slot_mac[i] == r.req_mac)
          begin
            hit = 1'b1;
            slot_valid[i] = 1'b0;
            o.status = ST_DONE;
          end
        end
      end
      default: begin
        o.status = ST_NOT_FOUND;
      end
    endcase
    return o;
  endfunction

  // random live slot, or -1 when the table holds only the local entry
  function automatic int pick_live_slot();
    int base;
    int idx;
    base = $urandom_range(Depth - 1);
    idx = -1;
    for (int i = 0; i < Depth; i++)
      if (idx < 0 && slot_valid[(base + i) % Depth]) idx = (base + i) % Depth;
    return idx;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [47:0] m;
    int          r;
    r = $urandom_range(99);
    m[47:32] = 16'($urandom_range(16'hFFFF));
    m[31:0] = $urandom;
    if (r < 8) m = '0;
    else if (r < 16) m = '1;
    return m;
  endfunction

  function automatic logic [31:0] rand_ip();
    int r;
    r = $urandom_range(99);
    if (r < 10) return own_ip;
    if (r < 65) return ip_pool[$urandom_range(PoolSize - 1)];
    if (r < 72) return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    int   k;
    pick = $urandom_range(99);
    k = pick_live_slot();
    r.req_ip = rand_ip();
    r.req_mac = rand_mac();
    if (pick < 25) begin
      r.req_type = REQ_LOOKUP;
      if (k >= 0 && $urandom_range(1)) r.req_ip = slot_ip[k];
    end else if (pick < 60) begin
      r.req_type = REQ_INSERT;
    end else if (pick < 75) begin
      r.req_type = REQ_UPDATE;
      if (k >= 0 && $urandom_range(1)) r.req_ip = slot_ip[k];
    end else begin
      r.req_type = REQ_DELETE;
      if (k >= 0 && $urandom_range(1)) begin
        r.req_ip = slot_ip[k];
        r.req_mac = slot_mac[k];
      end else if (k >= 0 && $urandom_range(1)) begin
        // right IP, MAC off by one bit
        r.req_ip = slot_ip[k];
        r.req_mac = slot_mac[k] ^ (48'h1 << $urandom_range(47));
      end
    end
    return r;
  endfunction

  function automatic vec_t row(req_kind_t kind, logic [31:0] ip, logic [47:0] mac,
                               logic typed, status_t st, logic [47:0] rmac);
    vec_t v;
    v.kind = kind;
    v.ip = ip;
    v.mac = mac;
    v.typed = typed;
    v.st = st;
    v.rmac = rmac;
    return v;
  endfunction

  task automatic issue(req_t r, logic typed, rsp_t want);
    rsp_t got;
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    got = arp_resolve(r);
    answer_q.push_back(typed ? want : got);
  endtask

  task automatic idle_for(int n);
    req_t noise;
    repeat (n) begin
      noise.req_type = 2'($urandom_range(3));
      noise.req_ip = $urandom;
      noise.req_mac = rand_mac();
      @(negedge clk);
      start <= 1'b0;
      req <= noise;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HOST_IP) own_ip = data[31:0];
    else if (addr == ADDR_HOST_MAC) own_mac = data[47:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_random(int n, logic calm);
    for (int j = 0; j < n; j++) begin
      if (!(calm && j < n / 2) && $urandom_range(99) < 15) idle_for(1);
      issue(rand_req(), 1'b0, '0);
    end
  endtask

  initial begin
    req_t r;
    rsp_t want;
    int   k;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycles = 0;
    for (int i = 0; i < 4; i++) seen[i] = 0;
    for (int i = 0; i < Depth; i++) begin
      slot_valid[i] = 1'b0;
      slot_ip[i] = '0;
      slot_mac[i] = '0;
    end
    own_ip = '0;
    own_mac = '0;
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // local entry is 0.0.0.0 with MAC zero after reset
    dir_tab.push_back(row(REQ_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 1, ST_DONE, 48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, ST_NOT_FOUND, 48'h0));
    dir_tab.push_back(row(REQ_INSERT, 32'h0, 48'h1234_5678_9ABC, 1, ST_PRESENT, 48'h0));
    dir_tab.push_back(row(REQ_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, ST_DONE,
                          48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, ST_DONE,
                          48'hFFFF_FFFF_FFFF));
    dir_tab.push_back(row(REQ_INSERT, 32'hFFFF_FFFF, 48'h0, 1, ST_PRESENT, 48'h0));
    dir_tab.push_back(row(REQ_DELETE, 32'h0, 48'h0, 1, ST_NOT_FOUND, 48'h0));
    dir_tab.push_back(row(REQ_UPDATE, 32'h0, 48'h0123_4567_89AB, 1, ST_DONE, 48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'h0, 48'h0, 1, ST_DONE, 48'h0123_4567_89AB));
    dir_tab.push_back(row(REQ_UPDATE, 32'h0A00_0001, 48'h5, 1, ST_NOT_FOUND, 48'h0));
    dir_tab.push_back(row(REQ_DELETE, 32'hFFFF_FFFF, 48'h0, 1, ST_NOT_FOUND, 48'h0));
    dir_tab.push_back(row(REQ_DELETE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, ST_DONE,
                          48'h0));
    // only the local entry left: delete must miss
    dir_tab.push_back(row(REQ_DELETE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, ST_NOT_FOUND,
                          48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, ST_NOT_FOUND, 48'h0));
    dir_tab.push_back(row(REQ_INSERT, 32'h0A00_0001, 48'h0, 1, ST_DONE, 48'h0));
    dir_tab.push_back(row(REQ_UPDATE, 32'h0A00_0001, 48'h8000_0000_0001, 1, ST_DONE,
                          48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'h0A00_0001, 48'h0, 0, ST_DONE, 48'h0));
    dir_tab.push_back(row(REQ_INSERT, 32'hC0A8_0101, 48'hAAAA_5555_AAAA, 0, ST_DONE,
                          48'h0));
    dir_tab.push_back(row(REQ_DELETE, 32'h0A00_0001, 48'h8000_0000_0001, 0, ST_DONE,
                          48'h0));
    dir_tab.push_back(row(REQ_LOOKUP, 32'hC0A8_0101, 48'h0, 0, ST_DONE, 48'h0));

    foreach (dir_tab[i]) begin
      r.req_type = dir_tab[i].kind;
      r.req_ip = dir_tab[i].ip;
      r.req_mac = dir_tab[i].mac;
      want.status = dir_tab[i].st;
      want.result_mac = dir_tab[i].rmac;
      issue(r, dir_tab[i].typed, want);
    end

    settle();
    cfg_write(ADDR_HOST_IP, {32'h0, 32'hFFFF_FFFF});
    cfg_write(ADDR_HOST_MAC, {16'h0, 48'hFFFF_FFFF_FFFF});
    run_random(200, 1'b1);

    // local address moved onto a live dynamic entry: local entry takes precedence
    settle();
    k = pick_live_slot();
    cfg_write(ADDR_HOST_IP, {32'h0, (k >= 0) ? slot_ip[k] : 32'($urandom)});
    cfg_write(ADDR_HOST_MAC, {16'h0, rand_mac()});
    run_random(200, 1'b0);

    settle();
    cfg_write(ADDR_HOST_MAC, '0);
    cfg_write(ADDR_HOST_IP, '0);
    run_random(200, 1'b0);

    settle();
    cfg_write(ADDR_HOST_IP, {32'h0, 32'($urandom)});
    cfg_write(ADDR_HOST_MAC, {16'h0, rand_mac()});
    run_random(230, 1'b0);

    settle();
    repeat (DrainCycles) @(posedge clk);

    $display("%0d requests over five local-entry settings: %0d done, %0d not found,",
             dir_tab.size() + 830, seen[ST_DONE], seen[ST_NOT_FOUND]);
    $display("%0d refused as present, %0d refused as full", seen[ST_PRESENT],
             seen[ST_FULL]);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("arp_cache_table regression: pass");
    end else begin
      $display("arp_cache_table regression: fail");
    end
    $finish;
  end

endmodule
